// ===== hw/rtl/prle_pkg.sv =====
// Shared constants, types and a helper function for the planar run-length image decoder.
package prle_pkg;

	localparam int ROW_BYTES   = 80;
	localparam int ROWS        = 350;
	localparam int PLANES      = 4;
	localparam int PLANE_BYTES = ROW_BYTES * ROWS;
	localparam int STORE_BYTES = PLANES * PLANE_BYTES;
	localparam int READ_PLANES = (PLANES < 4) ? PLANES : 4;

	localparam int POS_W  = $clog2(PLANE_BYTES);
	localparam int PIDX_W = $clog2(PLANES + 1);
	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam int WA_W   = $clog2(STORE_BYTES + 1);

	localparam logic [1:0] ACT_FEED    = 2'd0;
	localparam logic [1:0] ACT_READ    = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	localparam logic [7:0] LITERAL_HDR = 8'd128;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_READ,
		ST_DRAIN,
		ST_OUT
	} state_t;

	// Places the bits of one plane byte into the plane's bit of each of the eight pixels.
	function automatic logic [31:0] merge_plane(input logic [31:0] acc, input logic [7:0] v,
			input logic [1:0] p);
		logic [31:0] r;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			r[5'(28 - 4 * i + int'(p))] = r[5'(28 - 4 * i + int'(p))] | v[3'(7 - i)];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/prle_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module prle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/planar_rle_image_decoder.sv =====
// Top level of the planar run-length image decoder with its plane store and control.
//
//  Channel  | Direction | Handshake               | Payload
//  request  | in        | req_valid / req_stall   | action, data_byte, read_row, read_column
//  response | out       | rsp_valid / rsp_stall   | pixels, decode_done
//
// A header, a literal byte, a restart or an unused action is handled in the idle state.
// A repeat byte is accepted and then written one plane byte per cycle in the run state,
// up to 128, since the plane store has a single write port.
// A read issues one store read per plane in the read state, then passes the drain and output states.
// Reset clears the control state but not the plane store; undecoded store bytes are masked by decode progress.
// A stalled response holds its register, and a later read waits in its output state.
module planar_rle_image_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  data_byte,
	input  logic [8:0]  read_row,
	input  logic [6:0]  read_column,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] pixels,
	output logic        decode_done
);

	import prle_pkg::*;

	state_t              state_q, state_d;
	logic [PIDX_W-1:0]   plane_index_q, plane_index_d;
	logic [POS_W-1:0]    write_position_q, write_position_d;
	logic [WA_W-1:0]     wr_addr_q, wr_addr_d;
	logic [7:0]          run_left_q, run_left_d;
	logic                literal_mode_q, literal_mode_d;
	logic [7:0]          rep_byte_q;

	logic [POS_W-1:0]    rd_pos_q;
	logic                rd_ok_q;
	logic [ADDR_W-1:0]   rd_addr_q;
	logic [PIDX_W-1:0]   rd_plane_q;
	logic                rd_vld_s1;
	logic                rd_mask_s1;
	logic [1:0]          rd_plane_s1;
	logic [31:0]         pix_q;

	logic                rsp_valid_q;
	logic [31:0]         pixels_q;
	logic                decode_done_q;

	logic                accept;
	logic                done;
	logic                put_en;
	logic [7:0]          put_data;
	logic                last_put;
	logic                rd_issue;
	logic                rd_decoded;
	logic                rsp_load;
	logic [31:0]         pos_full;
	logic                range_ok;
	logic [7:0]          ram_rdata;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign done      = (plane_index_q == PIDX_W'(PLANES));
	assign last_put  = (plane_index_q == PIDX_W'(PLANES - 1)) &&
			(write_position_q == POS_W'(PLANE_BYTES - 1));

	assign pos_full = 32'(read_row) * 32'(ROW_BYTES) + 32'(read_column);
	assign range_ok = (32'(read_row) < 32'(ROWS)) && (32'(read_column) < 32'(ROW_BYTES));

	assign rd_issue   = (state_q == ST_READ);
	assign rd_decoded = rd_ok_q && ((rd_plane_q < plane_index_q) ||
			((rd_plane_q == plane_index_q) && (rd_pos_q < write_position_q)));
	assign rsp_load   = (state_q == ST_OUT) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		state_d          = state_q;
		plane_index_d    = plane_index_q;
		write_position_d = write_position_q;
		wr_addr_d        = wr_addr_q;
		run_left_d       = run_left_q;
		literal_mode_d   = literal_mode_q;
		put_en           = 1'b0;
		put_data         = data_byte;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (action)
						ACT_FEED: begin
							if (!done) begin
								if (run_left_q == 8'd0) begin
									if (data_byte < LITERAL_HDR) begin
										run_left_d     = data_byte + 8'd1;
										literal_mode_d = 1'b0;
									end else begin
										run_left_d     = data_byte - 8'd127;
										literal_mode_d = 1'b1;
									end
								end else if (literal_mode_q) begin
									put_en     = 1'b1;
									run_left_d = run_left_q - 8'd1;
								end else begin
									state_d = ST_RUN;
								end
							end
						end
						ACT_READ: begin
							state_d = ST_READ;
						end
						ACT_RESTART: begin
							plane_index_d    = '0;
							write_position_d = '0;
							wr_addr_d        = '0;
							run_left_d       = '0;
							literal_mode_d   = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_RUN: begin
				put_en   = 1'b1;
				put_data = rep_byte_q;
				if ((run_left_q == 8'd1) || last_put) begin
					run_left_d = '0;
					state_d    = ST_IDLE;
				end else begin
					run_left_d = run_left_q - 8'd1;
				end
			end
			ST_READ: begin
				if (rd_plane_q == PIDX_W'(READ_PLANES - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (put_en) begin
			wr_addr_d = wr_addr_q + WA_W'(1);
			if (write_position_q == POS_W'(PLANE_BYTES - 1)) begin
				write_position_d = '0;
				plane_index_d    = plane_index_q + PIDX_W'(1);
			end else begin
				write_position_d = write_position_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			plane_index_q    <= '0;
			write_position_q <= '0;
			wr_addr_q        <= '0;
			run_left_q       <= '0;
			literal_mode_q   <= 1'b0;
			rd_vld_s1        <= 1'b0;
			rsp_valid_q      <= 1'b0;
		end else begin
			state_q          <= state_d;
			plane_index_q    <= plane_index_d;
			write_position_q <= write_position_d;
			wr_addr_q        <= wr_addr_d;
			run_left_q       <= run_left_d;
			literal_mode_q   <= literal_mode_d;
			rd_vld_s1        <= rd_issue;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (action == ACT_FEED)) begin
			rep_byte_q <= data_byte;
		end
		if (accept && (action == ACT_READ)) begin
			rd_pos_q   <= POS_W'(pos_full);
			rd_ok_q    <= range_ok;
			rd_addr_q  <= ADDR_W'(POS_W'(pos_full));
			rd_plane_q <= '0;
			pix_q      <= '0;
		end else begin
			if (rd_issue) begin
				rd_addr_q  <= rd_addr_q + ADDR_W'(PLANE_BYTES);
				rd_plane_q <= rd_plane_q + PIDX_W'(1);
			end
			if (rd_vld_s1 && rd_mask_s1) begin
				pix_q <= merge_plane(pix_q, ram_rdata, rd_plane_s1);
			end
		end
		rd_mask_s1  <= rd_decoded;
		rd_plane_s1 <= 2'(rd_plane_q);
		if (rsp_load) begin
			pixels_q      <= pix_q;
			decode_done_q <= done;
		end
	end

	prle_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_plane_store (
		.clk  (clk),
		.we   (put_en),
		.waddr(ADDR_W'(wr_addr_q)),
		.wdata(put_data),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	assign rsp_valid   = rsp_valid_q;
	assign pixels      = pixels_q;
	assign decode_done = decode_done_q;

	a_feed_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
			(accept && (action != ACT_READ) && !rsp_valid_q) |=> !rsp_valid_q)
		else $error("A request other than a read produced a response.");

	a_done_addr: assert property (@(posedge clk) disable iff (!arst_n)
			(done == (wr_addr_q == WA_W'(STORE_BYTES))))
		else $error("Decode progress and write address disagree.");

	a_run_live: assert property (@(posedge clk) disable iff (!arst_n)
			(state_q == ST_RUN) |-> ((run_left_q != 8'd0) && !done))
		else $error("Repeat run active with nothing left to write.");

endmodule

// ===== tb/tb_planar_rle_image_decoder.sv =====
// Self-checking testbench for the planar run-length image decoder with its own decoding model.
module tb_planar_rle_image_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import prle_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [31:0] pix;
		logic        done;
	} pixel_group_t;

	typedef struct packed {
		logic [1:0]  act;
		logic [7:0]  b;
		logic [8:0]  r;
		logic [6:0]  c;
		logic        known;
		logic [31:0] pix;
		logic        done;
	} directed_row_t;

	localparam directed_row_t DIRECTED [25] = '{
		'{ACT_READ,    8'h00, 9'd0,   7'd0,   1'b1, 32'h0000_0000, 1'b0},
		'{ACT_READ,    8'h00, 9'd349, 7'd79,  1'b1, 32'h0000_0000, 1'b0},
		'{ACT_READ,    8'h00, 9'd350, 7'd0,   1'b1, 32'h0000_0000, 1'b0},
		'{ACT_READ,    8'hFF, 9'd511, 7'd127, 1'b1, 32'h0000_0000, 1'b0},
		'{ACT_READ,    8'h00, 9'd0,   7'd80,  1'b1, 32'h0000_0000, 1'b0},
		'{ACT_UNUSED,  8'hFF, 9'd511, 7'd127, 1'b0, 32'h0000_0000, 1'b0},
		'{ACT_FEED,    8'h80, 9'd0,   7'd0,   1'b0, 32'h0000_0000, 1'b0},
		'{ACT_FEED,    8'hFF, 9'd0,   7'd0,   1'b0, 32'h0000_0000, 1'b0},
		'{ACT_READ,    8'h00, 9'd0,   7'd0,   1'b1, 32'h1111_1111, 1'b0},
		'{ACT_FEED,    8'h81, 9'd0,   7'd0,   1'b0, 32'h0000_0000, 1'b0},
		'{ACT_FEED,    8'hA5, 9'd0,   7'd0,   1'b0, 32'h0000_0000, 1'b0},
		'{ACT_FEED,    8'h00, 9'd0,   7'd0,   1'b0, 32'h0000_0000, 1'b0},
		'{ACT_FEED,    8'h7F, 9'd0,   7'd0,   1'b0, 32'h0000_0000, 1'b0},
		'{ACT_FEED,    8'h3C, 9'd0,   7'd0,   1'b0, 32'h0000_0000, 1'b0},
		'{ACT_FEED,    8'h00, 9'd0,   7'd0,   1'b0, 32'h0000_0000, 1'b0},
		'{ACT_FEED,    8'hC3, 9'd0,   7'd0,   1'b0, 32'h0000_0000, 1'b0},
		'{ACT_READ,    8'h00, 9'd0,   7'd1,   1'b0, 32'h0000_0000, 1'b0},
		'{ACT_READ,    8'h00, 9'd1,   7'd51,  1'b0, 32'h0000_0000, 1'b0},
		'{ACT_READ,    8'h00, 9'd1,   7'd52,  1'b1, 32'h0000_0000, 1'b0},
		'{ACT_RESTART, 8'h00, 9'd0,   7'd0,   1'b0, 32'h0000_0000, 1'b0},
		'{ACT_READ,    8'h00, 9'd0,   7'd0,   1'b1, 32'h0000_0000, 1'b0},
		'{ACT_FEED,    8'h80, 9'd0,   7'd0,   1'b0, 32'h0000_0000, 1'b0},
		'{ACT_FEED,    8'h5A, 9'd0,   7'd0,   1'b0, 32'h0000_0000, 1'b0},
		'{ACT_READ,    8'h00, 9'd0,   7'd0,   1'b0, 32'h0000_0000, 1'b0},
		'{ACT_RESTART, 8'hFF, 9'd511, 7'd127, 1'b0, 32'h0000_0000, 1'b0}
	};

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [1:0]  action;
	logic [7:0]  data_byte;
	logic [8:0]  read_row;
	logic [6:0]  read_column;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [31:0] pixels;
	logic        decode_done;

	logic [7:0]  img_store [STORE_BYTES];
	int unsigned cur_plane;
	int unsigned cur_pos;
	int unsigned bytes_owed;
	bit          literal_run;

	pixel_group_t pending_reads [$];
	int fail_count = 0;
	int items_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;

	planar_rle_image_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.action(action),
		.data_byte(data_byte),
		.read_row(read_row),
		.read_column(read_column),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.pixels(pixels),
		.decode_done(decode_done)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic void clear_decoder();
		cur_plane = 0;
		cur_pos = 0;
		bytes_owed = 0;
		literal_run = 1'b0;
	endfunction

	function automatic void store_byte(logic [7:0] v);
		if (cur_plane >= PLANES) return;
		img_store[ADDR_W'(cur_plane * PLANE_BYTES + cur_pos)] = v;
		cur_pos++;
		if (cur_pos >= PLANE_BYTES) begin
			cur_pos = 0;
			cur_plane++;
		end
	endfunction

	function automatic void decode_byte(logic [7:0] b);
		if (cur_plane >= PLANES) return;
		if (bytes_owed == 0) begin
			if (b < LITERAL_HDR) begin
				bytes_owed = b + 1;
				literal_run = 1'b0;
			end else begin
				bytes_owed = b - 127;
				literal_run = 1'b1;
			end
		end else if (literal_run) begin
			store_byte(b);
			bytes_owed--;
		end else begin
			while (bytes_owed != 0 && cur_plane < PLANES) begin
				store_byte(b);
				bytes_owed--;
			end
			bytes_owed = 0;
		end
	endfunction

	function automatic logic [31:0] decoded_pixels(int unsigned r, int unsigned c);
		int unsigned pos;
		logic [31:0] acc;
		logic [7:0] v;
		acc = '0;
		if (r >= ROWS || c >= ROW_BYTES) return acc;
		pos = r * ROW_BYTES + c;
		for (int p = 0; p < PLANES && p < 4; p++) begin
			if (p < cur_plane || (p == cur_plane && pos < cur_pos)) begin
				v = img_store[ADDR_W'(p * PLANE_BYTES + pos)];
				for (int i = 0; i < 8; i++) begin
					acc[5'(28 - 4 * i + p)] = acc[5'(28 - 4 * i + p)] | v[3'(7 - i)];
				end
			end
		end
		return acc;
	endfunction

	task automatic send_request(input logic [1:0] act, input logic [7:0] b, input logic [8:0] r,
			input logic [6:0] c, input bit known, input logic [31:0] k_pix, input bit k_done);
		pixel_group_t exp_group;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		action <= act;
		data_byte <= b;
		read_row <= r;
		read_column <= c;
		do @(posedge clk); while (req_stall);
		items_sent++;
		case (act)
			ACT_FEED: decode_byte(b);
			ACT_READ: begin
				if (known) begin
					exp_group.pix = k_pix;
					exp_group.done = k_done;
				end else begin
					exp_group.pix = decoded_pixels(r, c);
					exp_group.done = (cur_plane >= PLANES);
				end
				pending_reads.push_back(exp_group);
			end
			ACT_RESTART: clear_decoder();
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic feed_byte(input logic [7:0] b);
		send_request(ACT_FEED, b, 9'($urandom), 7'($urandom), 1'b0, '0, 1'b0);
	endtask

	task automatic read_at(input logic [8:0] r, input logic [6:0] c);
		send_request(ACT_READ, 8'($urandom), r, c, 1'b0, '0, 1'b0);
	endtask

	task automatic send_other(input logic [1:0] act);
		send_request(act, 8'($urandom), 9'($urandom), 7'($urandom), 1'b0, '0, 1'b0);
	endtask

	task automatic read_somewhere();
		int unsigned span;
		int unsigned pos;
		if ($urandom_range(0, 3) == 0) begin
			read_at(9'($urandom_range(0, 511)), 7'($urandom_range(0, 127)));
		end else begin
			span = (cur_plane > 0) ? PLANE_BYTES : cur_pos + 1;
			pos = $urandom_range(0, span - 1);
			read_at(9'(pos / ROW_BYTES), 7'(pos % ROW_BYTES));
		end
	endtask

	// Long repeats, some literals and reads; the last run always overshoots the image end.
	task automatic fill_image();
		int left;
		int run;
		int len;
		while (cur_plane < PLANES) begin
			left = (PLANES - cur_plane) * PLANE_BYTES - cur_pos;
			if ($urandom_range(0, 99) < 3) begin
				read_somewhere();
			end else if (left > 300 && $urandom_range(0, 99) < 2) begin
				len = $urandom_range(0, 7);
				feed_byte(8'(LITERAL_HDR + len));
				for (int i = 0; i <= len; i++) feed_byte(8'($urandom));
			end else begin
				if (left < 128) run = 128;
				else if (left == 128) run = 100;
				else run = $urandom_range(124, 128);
				feed_byte(8'(run - 1));
				feed_byte(8'($urandom));
			end
		end
	endtask

	task automatic random_traffic(input int count);
		int stop_at;
		int pick;
		int len;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				feed_byte(8'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 15) :
					$urandom_range(0, 127)));
				feed_byte(8'($urandom));
			end else if (pick < 62) begin
				len = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 127);
				feed_byte(8'(LITERAL_HDR + len));
				for (int i = 0; i <= len; i++) feed_byte(8'($urandom));
			end else if (pick < 90) begin
				read_somewhere();
			end else if (pick < 95) begin
				feed_byte(8'($urandom));
			end else if (pick < 98) begin
				send_other(ACT_UNUSED);
			end else if (pick < 99) begin
				send_other(ACT_RESTART);
			end else begin
				read_at(9'($urandom_range(350, 511)), 7'($urandom_range(0, 127)));
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= 400;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		pixel_group_t exp_group;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_reads.size() == 0) begin
				$error("response with no read request pending: pixels %h, decode_done %b",
					pixels, decode_done);
				fail_count++;
			end else begin
				exp_group = pending_reads.pop_front();
				if (pixels !== exp_group.pix) begin
					$error("pixels: expected %h, actual %h", exp_group.pix, pixels);
					fail_count++;
				end
				if (decode_done !== exp_group.done) begin
					$error("decode_done: expected %b, actual %b", exp_group.done, decode_done);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		action = ACT_FEED;
		data_byte = '0;
		read_row = '0;
		read_column = '0;
		clear_decoder();
		send_idle_pct = 20;
		recv_idle_pct = 67;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 25; i++) begin
			send_request(DIRECTED[i].act, DIRECTED[i].b, DIRECTED[i].r, DIRECTED[i].c,
				DIRECTED[i].known, DIRECTED[i].pix, DIRECTED[i].done);
		end

		send_other(ACT_RESTART);
		fill_image();
		read_at(9'd349, 7'd79);
		read_at(9'd0, 7'd0);
		feed_byte(8'h05);
		feed_byte(8'hAA);
		feed_byte(8'h81);
		feed_byte(8'h11);
		read_at(9'd349, 7'd79);
		send_other(ACT_RESTART);
		read_at(9'd0, 7'd0);

		random_traffic(50);
		send_idle_pct = 67;
		recv_idle_pct = 20;
		random_traffic(50);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests++;
		repeat (16) read_somewhere();
		random_traffic(50);
		req_valid <= 1'b0;

		while (pending_reads.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/prle_pkg.sv
hw/rtl/prle_ram.sv
hw/rtl/planar_rle_image_decoder.sv
tb/tb_planar_rle_image_decoder.sv
